[design/gttprc_pkg.sv]
// Shared types and constants for the page-table entry run classifier.
// Used by gttprc_decode and gtt_pte_run_classifier_core; no dependencies.
`timescale 1ns / 1ps

package gttprc_pkg;

  localparam int INDEX_BITS_DEFAULT = 20;
  localparam int OUT_INDEX_BITS     = 20;
  localparam int ADDR_BITS          = 40;
  localparam int ENTRY_BITS         = 64;
  localparam int CFG_ADDR_BITS      = 4;
  localparam int CFG_DATA_BITS      = 32;

  localparam logic [ADDR_BITS:0] PAGE_SIZE = (ADDR_BITS + 1)'(4096);

  localparam logic [3:0] GEN3       = 4'd3;
  localparam logic [3:0] GEN4       = 4'd4;
  localparam logic [3:0] GEN5       = 4'd5;
  localparam logic [3:0] GEN6       = 4'd6;
  localparam logic [3:0] GEN7       = 4'd7;
  localparam logic [3:0] GEN9       = 4'd9;
  localparam logic [3:0] GEN_RESET  = GEN6;

  localparam logic [1:0] REG_GENERATION   = 2'd0;
  localparam logic [1:0] REG_EXTENDED_G33 = 2'd1;
  localparam logic [1:0] REG_NARROW_HIGH  = 2'd2;

  localparam logic [1:0] KIND_SINGLE   = 2'd0;
  localparam logic [1:0] KIND_LINEAR   = 2'd1;
  localparam logic [1:0] KIND_CONSTANT = 2'd2;

  typedef enum logic [2:0] {
    MODE_UNDECIDED = 3'b001,
    MODE_LINEAR    = 3'b010,
    MODE_CONSTANT  = 3'b100
  } run_mode_t;

  typedef struct packed {
    logic [3:0] generation;
    logic       extended_g33;
    logic       narrow_high_bits;
  } cfg_t;

  typedef struct packed {
    logic                      table_done;
    logic [1:0]                run_kind;
    logic [ADDR_BITS-1:0]      start_address;
    logic [OUT_INDEX_BITS-1:0] last_index;
    logic [OUT_INDEX_BITS-1:0] first_index;
  } result_t;

  function automatic logic [1:0] mode_kind(run_mode_t mode);
    logic [1:0] kind;
    case (mode)
      MODE_LINEAR:   kind = KIND_LINEAR;
      MODE_CONSTANT: kind = KIND_CONSTANT;
      default:       kind = KIND_SINGLE;
    endcase
    return kind;
  endfunction

endpackage

[design/gttprc_decode.sv]
// Entry decode: raw page-table entry to a 4 KiB-aligned physical address.
// Depends on gttprc_pkg for the configuration struct and generation codes.
`timescale 1ns / 1ps

module gttprc_decode (
  input  logic [gttprc_pkg::ENTRY_BITS-1:0] entry_word,
  input  gttprc_pkg::cfg_t                  cfg,
  output logic [gttprc_pkg::ADDR_BITS-1:0]  address
);

  logic [31:0] low;

  assign low = entry_word[31:0];

  always_comb begin
    if (cfg.generation < gttprc_pkg::GEN4 && !cfg.extended_g33) begin
      address = {8'b0, low[31:12], 12'b0};
    end else begin
      case (cfg.generation)
        gttprc_pkg::GEN3, gttprc_pkg::GEN4, gttprc_pkg::GEN5: begin
          address = {4'b0, low[7:4], low[31:12], 12'b0};
        end
        gttprc_pkg::GEN6, gttprc_pkg::GEN7: begin
          if (cfg.narrow_high_bits) begin
            address = {1'b0, low[10:4], low[31:12], 12'b0};
          end else begin
            address = {low[11:4], low[31:12], 12'b0};
          end
        end
        default: begin
          address = {1'b0, entry_word[38:12], 12'b0};
        end
      endcase
    end
  end

endmodule

[design/gtt_pte_run_classifier_core.sv]
// Top level of the page-table entry run classifier: config registers, run
// tracking and a four-entry result queue. Depends on gttprc_pkg, gttprc_decode.
`timescale 1ns / 1ps

// Entries are taken one per cycle in index order and decoded in the cycle they
// are accepted; the run state is updated at that edge and zero, one or two
// results are pushed into a four-entry result queue, presented on the master
// side from the next cycle at one result per transfer. s_tready stays high
// while the queue holds two results or fewer, so a steady stream runs at one
// entry per cycle as long as the sink keeps up; an entry that both breaks a run
// and ends the table yields two results. The entry index counts modulo
// 2^INDEX_BITS and restarts at zero after an entry marked with tlast.
// Generation writes outside 3 to 9 are ignored.
module gtt_pte_run_classifier_core #(
  parameter int INDEX_BITS = gttprc_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [gttprc_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [gttprc_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [gttprc_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                 pready,
  // entry stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [63:0]                          s_tdata,  // [63:0] entry_word
  input  logic                                 s_tlast,  // final_entry
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [19:0] first_index, [39:20] last_index, [79:40] start_address
  output logic [79:0]                          m_tdata,
  output logic [1:0]                           m_tuser,  // [1:0] run_kind
  output logic                                 m_tlast   // table_done
);

  localparam int DEPTH = 4;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  gttprc_pkg::cfg_t cfg;

  logic [INDEX_BITS-1:0]            entry_counter;
  logic [INDEX_BITS-1:0]            run_first;
  logic [gttprc_pkg::ADDR_BITS-1:0] run_address;
  logic [gttprc_pkg::ADDR_BITS-1:0] previous_address;
  gttprc_pkg::run_mode_t            run_mode;
  logic                             run_open;

  logic [INDEX_BITS-1:0]            entry_counter_next;
  logic [INDEX_BITS-1:0]            run_first_next;
  logic [gttprc_pkg::ADDR_BITS-1:0] run_address_next;
  logic [gttprc_pkg::ADDR_BITS-1:0] previous_address_next;
  gttprc_pkg::run_mode_t            run_mode_next;
  logic                             run_open_next;

  logic [gttprc_pkg::ADDR_BITS-1:0] address;
  logic [INDEX_BITS-1:0]            prev_idx;
  logic                             cfg_write;
  logic                             in_fire;
  logic                             out_fire;

  gttprc_pkg::result_t res0, res1;
  logic                res0_valid, res1_valid;

  gttprc_pkg::result_t queue [DEPTH];
  logic [PTR_BITS-1:0] wptr, rptr;
  logic [CNT_BITS-1:0] count;
  logic [1:0]          push_n;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.generation       <= gttprc_pkg::GEN_RESET;
      cfg.extended_g33     <= 1'b0;
      cfg.narrow_high_bits <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        gttprc_pkg::REG_GENERATION: begin
          if (pwdata[3:0] >= gttprc_pkg::GEN3 && pwdata[3:0] <= gttprc_pkg::GEN9) begin
            cfg.generation <= pwdata[3:0];
          end
        end
        gttprc_pkg::REG_EXTENDED_G33: cfg.extended_g33     <= pwdata[0];
        gttprc_pkg::REG_NARROW_HIGH:  cfg.narrow_high_bits <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gttprc_pkg::REG_GENERATION:   prdata = {28'b0, cfg.generation};
      gttprc_pkg::REG_EXTENDED_G33: prdata = {31'b0, cfg.extended_g33};
      gttprc_pkg::REG_NARROW_HIGH:  prdata = {31'b0, cfg.narrow_high_bits};
      default:                      prdata = '0;
    endcase
  end

  gttprc_decode u_decode (
    .entry_word (s_tdata),
    .cfg        (cfg),
    .address    (address)
  );

  // run tracking
  assign in_fire  = s_tvalid && s_tready;
  assign prev_idx = entry_counter - INDEX_BITS'(1);

  always_comb begin
    run_first_next        = run_first;
    run_address_next      = run_address;
    run_mode_next         = run_mode;
    run_open_next         = run_open;
    previous_address_next = address;
    entry_counter_next    = entry_counter + INDEX_BITS'(1);
    res0_valid            = 1'b0;
    res1_valid            = 1'b0;
    res0.table_done       = 1'b0;
    res0.run_kind         = gttprc_pkg::mode_kind(run_mode);
    res0.start_address    = run_address;
    res0.first_index      = gttprc_pkg::OUT_INDEX_BITS'(run_first);
    res0.last_index       = gttprc_pkg::OUT_INDEX_BITS'(prev_idx);

    if (!run_open) begin
      run_open_next    = 1'b1;
      run_first_next   = entry_counter;
      run_address_next = address;
      run_mode_next    = gttprc_pkg::MODE_UNDECIDED;
    end else begin
      case (run_mode)
        gttprc_pkg::MODE_UNDECIDED: begin
          if ({1'b0, address} == {1'b0, run_address} + gttprc_pkg::PAGE_SIZE) begin
            run_mode_next = gttprc_pkg::MODE_LINEAR;
          end else if (address == run_address) begin
            run_mode_next = gttprc_pkg::MODE_CONSTANT;
          end else begin
            res0_valid       = 1'b0 | 1'b1;
            res0.last_index  = gttprc_pkg::OUT_INDEX_BITS'(run_first);
          end
        end
        gttprc_pkg::MODE_LINEAR: begin
          if ({1'b0, address} != {1'b0, previous_address} + gttprc_pkg::PAGE_SIZE) begin
            res0_valid = 1'b1;
          end
        end
        default: begin
          if (address != run_address) begin
            res0_valid = 1'b1;
          end
        end
      endcase
      if (res0_valid) begin
        run_first_next   = entry_counter;
        run_address_next = address;
        run_mode_next    = gttprc_pkg::MODE_UNDECIDED;
      end
    end

    res1.table_done    = 1'b1;
    res1.run_kind      = gttprc_pkg::mode_kind(run_mode_next);
    res1.start_address = run_address_next;
    res1.first_index   = gttprc_pkg::OUT_INDEX_BITS'(run_first_next);
    res1.last_index    = gttprc_pkg::OUT_INDEX_BITS'(entry_counter);

    if (s_tlast) begin
      res1_valid            = 1'b1;
      entry_counter_next    = '0;
      run_first_next        = '0;
      run_address_next      = '0;
      previous_address_next = '0;
      run_mode_next         = gttprc_pkg::MODE_UNDECIDED;
      run_open_next         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_counter    <= '0;
      run_first        <= '0;
      run_address      <= '0;
      previous_address <= '0;
      run_mode         <= gttprc_pkg::MODE_UNDECIDED;
      run_open         <= 1'b0;
    end else if (in_fire) begin
      entry_counter    <= entry_counter_next;
      run_first        <= run_first_next;
      run_address      <= run_address_next;
      previous_address <= previous_address_next;
      run_mode         <= run_mode_next;
      run_open         <= run_open_next;
    end
  end

  // result queue
  assign s_tready = count <= CNT_BITS'(DEPTH - 2);
  assign m_tvalid = count != '0;
  assign out_fire = m_tvalid && m_tready;
  assign push_n   = in_fire ? ({1'b0, res0_valid} + {1'b0, res1_valid}) : 2'd0;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (res0_valid) begin
        queue[wptr] <= res0;
        if (res1_valid) begin
          queue[wptr + PTR_BITS'(1)] <= res1;
        end
      end else if (res1_valid) begin
        queue[wptr] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_BITS'(push_n);
      rptr  <= rptr + PTR_BITS'(out_fire);
      count <= count + CNT_BITS'(push_n) - CNT_BITS'(out_fire);
    end
  end

  assign m_tdata = {queue[rptr].start_address, queue[rptr].last_index,
                    queue[rptr].first_index};
  assign m_tuser = queue[rptr].run_kind;
  assign m_tlast = queue[rptr].table_done;

endmodule

[bench/gtt_pte_run_classifier_core_test.sv]
// Self-checking bench for gtt_pte_run_classifier_core: drives entry tables and
// register writes, predicts the reported runs and compares each result transfer.
// Depends on gttprc_pkg and the core under design/.
`timescale 1ns / 1ps

module gtt_pte_run_classifier_core_test;

  localparam logic [3:0] GEN8 = 4'd8;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  gtt_pte_run_classifier_core uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // classifier shadow state
  logic [3:0]  cfg_gen = gttprc_pkg::GEN_RESET;
  logic        cfg_ext = 1'b0;
  logic        cfg_narrow = 1'b0;
  logic [19:0] entry_index = '0;
  logic [19:0] run_first = '0;
  logic [39:0] run_addr = '0;
  logic [39:0] prev_addr = '0;
  gttprc_pkg::run_mode_t run_mode = gttprc_pkg::MODE_UNDECIDED;
  logic        run_open = 1'b0;

  gttprc_pkg::result_t expected_runs[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  function automatic logic [39:0] page_address(logic [63:0] word);
    logic [39:0] low40;
    logic [39:0] addr;
    low40 = {8'd0, word[31:0]};
    if (cfg_gen < gttprc_pkg::GEN4 && !cfg_ext) begin
      addr = low40;
    end else begin
      case (cfg_gen)
        gttprc_pkg::GEN3, gttprc_pkg::GEN4, gttprc_pkg::GEN5:
          addr = low40 | {4'd0, word[7:4], 32'd0};
        gttprc_pkg::GEN6, gttprc_pkg::GEN7: begin
          if (cfg_narrow) addr = low40 | {1'b0, word[10:4], 32'd0};
          else addr = low40 | {word[11:4], 32'd0};
        end
        default: addr = {1'b0, word[38:12], 12'd0};
      endcase
    end
    addr[11:0] = 12'd0;
    return addr;
  endfunction

  function automatic gttprc_pkg::result_t make_run(logic [1:0] kind, logic [19:0] first,
                                                   logic [19:0] last, logic [39:0] addr,
                                                   logic done);
    gttprc_pkg::result_t r;
    r.run_kind = kind;
    r.first_index = first;
    r.last_index = last;
    r.start_address = addr;
    r.table_done = done;
    return r;
  endfunction

  task automatic start_run(input logic [19:0] idx, input logic [39:0] addr);
    run_open = 1'b1;
    run_first = idx;
    run_addr = addr;
    run_mode = gttprc_pkg::MODE_UNDECIDED;
  endtask

  task automatic classify_entry(input logic [63:0] word, input logic last_flag);
    logic [39:0] addr;
    logic [19:0] idx;
    logic [19:0] prev_idx;
    logic [1:0]  kind;
    addr = page_address(word);
    idx = entry_index;
    prev_idx = idx - 20'd1;
    if (!run_open) begin
      start_run(idx, addr);
    end else if (run_mode == gttprc_pkg::MODE_UNDECIDED) begin
      if ({1'b0, addr} == {1'b0, run_addr} + gttprc_pkg::PAGE_SIZE) begin
        run_mode = gttprc_pkg::MODE_LINEAR;
      end else if (addr == run_addr) begin
        run_mode = gttprc_pkg::MODE_CONSTANT;
      end else begin
        expected_runs.push_back(make_run(gttprc_pkg::KIND_SINGLE, run_first, run_first,
                                         run_addr, 1'b0));
        start_run(idx, addr);
      end
    end else if (run_mode == gttprc_pkg::MODE_LINEAR) begin
      if ({1'b0, addr} != {1'b0, prev_addr} + gttprc_pkg::PAGE_SIZE) begin
        expected_runs.push_back(make_run(gttprc_pkg::KIND_LINEAR, run_first, prev_idx,
                                         run_addr, 1'b0));
        start_run(idx, addr);
      end
    end else if (addr != run_addr) begin
      expected_runs.push_back(make_run(gttprc_pkg::KIND_CONSTANT, run_first, prev_idx,
                                       run_addr, 1'b0));
      start_run(idx, addr);
    end
    prev_addr = addr;
    entry_index = idx + 20'd1;
    if (last_flag) begin
      case (run_mode)
        gttprc_pkg::MODE_LINEAR:   kind = gttprc_pkg::KIND_LINEAR;
        gttprc_pkg::MODE_CONSTANT: kind = gttprc_pkg::KIND_CONSTANT;
        default:                   kind = gttprc_pkg::KIND_SINGLE;
      endcase
      expected_runs.push_back(make_run(kind, run_first, idx, run_addr, 1'b1));
      entry_index = '0;
      run_first = '0;
      run_addr = '0;
      prev_addr = '0;
      run_mode = gttprc_pkg::MODE_UNDECIDED;
      run_open = 1'b0;
    end
  endtask

  task automatic send_entry(input logic [63:0] word, input logic last_flag);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tlast <= last_flag;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    classify_entry(word, last_flag);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write one register, then read it back against the shadow copy
  task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    wait_idle();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      gttprc_pkg::REG_GENERATION:
        if (value[3:0] >= gttprc_pkg::GEN3 && value[3:0] <= gttprc_pkg::GEN9)
          cfg_gen = value[3:0];
      gttprc_pkg::REG_EXTENDED_G33: cfg_ext = value[0];
      default: cfg_narrow = value[0];
    endcase
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      gttprc_pkg::REG_GENERATION: want = {28'd0, cfg_gen};
      gttprc_pkg::REG_EXTENDED_G33: want = {31'd0, cfg_ext};
      default: want = {31'd0, cfg_narrow};
    endcase
    if (readback !== want) begin
      $display("%0t: register %0d readback expected %0h got %0h", $time, idx, want, readback);
      errors++;
    end
  endtask

  task automatic set_config(input logic [3:0] gen, input logic ext, input logic narrow);
    set_register(gttprc_pkg::REG_GENERATION, {28'd0, gen});
    set_register(gttprc_pkg::REG_EXTENDED_G33, {31'd0, ext});
    set_register(gttprc_pkg::REG_NARROW_HIGH, {31'd0, narrow});
  endtask

  task automatic random_config();
    if ($urandom_range(3) == 0) set_register(gttprc_pkg::REG_GENERATION, $urandom_range(0, 15));
    set_config(4'($urandom_range(3, 9)), 1'($urandom), 1'($urandom));
  endtask

  task automatic test_registers();
    set_register(gttprc_pkg::REG_GENERATION, 32'd0);
    set_register(gttprc_pkg::REG_GENERATION, 32'd2);
    set_register(gttprc_pkg::REG_GENERATION, 32'd10);
    set_register(gttprc_pkg::REG_GENERATION, 32'd15);
    set_config(gttprc_pkg::GEN3, 1'b1, 1'b1);
    set_config(gttprc_pkg::GEN9, 1'b0, 1'b0);
  endtask

  task automatic test_decode();
    set_config(gttprc_pkg::GEN3, 1'b0, 1'b0);
    send_entry('1, 1'b1);
    send_entry('0, 1'b1);
    wait_idle();
    set_config(gttprc_pkg::GEN3, 1'b1, 1'b0);
    send_entry('1, 1'b1);
    set_config(gttprc_pkg::GEN4, 1'b0, 1'b0);
    send_entry(64'h0000_0000_ABCD_E0F5, 1'b1);
    set_config(gttprc_pkg::GEN5, 1'b0, 1'b0);
    send_entry('1, 1'b1);
    set_config(gttprc_pkg::GEN6, 1'b0, 1'b0);
    send_entry('1, 1'b1);
    set_config(gttprc_pkg::GEN6, 1'b0, 1'b1);
    send_entry('1, 1'b1);
    set_config(gttprc_pkg::GEN7, 1'b0, 1'b0);
    send_entry(64'hFFFF_FFFF_0000_0A50, 1'b1);
    set_config(GEN8, 1'b0, 1'b0);
    send_entry('1, 1'b1);
    set_config(gttprc_pkg::GEN9, 1'b0, 1'b0);
    send_entry(64'h8000_00A5_5A5A_5FFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_runs();
    set_config(gttprc_pkg::GEN6, 1'b0, 1'b0);
    send_entry(64'h0000_0000_1000_0030, 1'b0);
    send_entry(64'h0000_0000_1000_1030, 1'b0);
    send_entry(64'h0000_0000_1000_2030, 1'b0);
    send_entry(64'h0000_0000_5555_5000, 1'b0);
    send_entry(64'h0000_0000_5555_5007, 1'b0);
    send_entry(64'h0000_0000_5555_5000, 1'b1);
    // top page then a wrapped successor: never linear, and final breaks a run
    send_entry(64'h0000_0000_FFFF_FFFF, 1'b0);
    send_entry(64'h0000_0000_0000_0000, 1'b1);
    wait_idle();
  endtask

  task automatic test_mid_table_config();
    set_config(gttprc_pkg::GEN6, 1'b0, 1'b0);
    send_entry(64'h0000_0000_1234_5000, 1'b0);
    wait_idle();
    set_config(gttprc_pkg::GEN9, 1'b0, 1'b0);
    send_entry(64'hFF00_0000_1234_6000, 1'b0);
    send_entry(64'h0000_0000_1234_7ABC, 1'b1);
    wait_idle();
  endtask

  task automatic random_tables(input int n_items);
    int sent;
    int table_len;
    int pos;
    int run_len;
    int shape;
    int k;
    logic [63:0] word;
    sent = 0;
    while (sent < n_items) begin
      if (sent != 0 && $urandom_range(3) == 0) begin
        wait_idle();
        random_config();
      end
      table_len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 14);
      pos = 0;
      while (pos < table_len) begin
        shape = $urandom_range(9);
        run_len = $urandom_range(1, 6);
        word = {$urandom, $urandom};
        for (k = 0; k < run_len && pos < table_len; k++) begin
          send_entry(word, pos == table_len - 1);
          pos++;
          sent++;
          if (shape < 4) word = word + 64'h1000;
          else if (shape >= 8) word = {$urandom, $urandom};
          word[3:0] = 4'($urandom);
          word[63:40] = 24'($urandom);
        end
      end
    end
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input int n_items);
    wait_idle();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    random_config();
    random_tables(n_items);
  endtask

  task automatic check_field(input string name, input logic [39:0] want, input logic [39:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    gttprc_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_runs.size() == 0) begin
        $display("%0t: unexpected result transfer, got %0h kind %0d done %0b",
                 $time, m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = expected_runs.pop_front();
        check_field("run_kind", 40'(want.run_kind), 40'(m_tuser));
        check_field("first_index", 40'(want.first_index), 40'(m_tdata[19:0]));
        check_field("last_index", 40'(want.last_index), 40'(m_tdata[39:20]));
        check_field("start_address", want.start_address, m_tdata[79:40]);
        check_field("table_done", 40'(want.table_done), 40'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_registers();
    test_decode();
    test_runs();
    test_mid_table_config();
    random_phase(0, 0, 180);
    random_phase(77, 0, 170);
    random_phase(0, 77, 170);
    random_phase(27, 27, 180);
    wait_idle();
    if (errors == 0 && expected_runs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/gttprc_pkg.sv
design/gttprc_decode.sv
design/gtt_pte_run_classifier_core.sv
bench/gtt_pte_run_classifier_core_test.sv
